@@ rtl/core/vmix_pkg.sv @@
// ----------------------------------------------------------------------------
// vmix_pkg - voice mixer shared definitions
// Voice table sizes, item kinds, beat payload types and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package vmix_pkg;

  localparam int VOICES      = 16;
  localparam int VOICE_BITS  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int LENGTH_BITS = 24;

  // Input item kinds
  localparam logic [2:0] KIND_PLAY     = 3'd0;
  localparam logic [2:0] KIND_SAMPLE   = 3'd1;
  localparam logic [2:0] KIND_STOP     = 3'd2;
  localparam logic [2:0] KIND_STOP_ALL = 3'd3;
  localparam logic [2:0] KIND_FRAME    = 3'd4;

  // Result kinds
  localparam logic REPLY_GRANT = 1'b0;
  localparam logic REPLY_FRAME = 1'b1;

  localparam logic [7:0] MASTER_RESET = 8'd200;
  localparam logic [7:0] PAN_FULL     = 8'd255;
  localparam logic [7:0] CENTRE_LO    = 8'd96;
  localparam logic [7:0] CENTRE_HI    = 8'd160;

  localparam logic signed [18:0] SAT_MAX = 19'sd32767;
  localparam logic signed [18:0] SAT_MIN = -19'sd32768;

  typedef struct packed {
    logic        [2:0]  kind;
    logic        [3:0]  voice;
    logic signed [15:0] sample;
    logic        [23:0] sound_length;
    logic        [7:0]  gain;
    logic        [7:0]  balance;
  } vmix_in_t;

  typedef struct packed {
    logic               reply_kind;
    logic        [3:0]  granted_voice;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic        [15:0] active_mask;
  } vmix_out_t;

  typedef struct packed {
    logic [7:0]             gain;
    logic [7:0]             balance;
    logic [LENGTH_BITS-1:0] count;
  } vmix_entry_t;

  // Voice table write command
  typedef struct packed {
    logic                  entry_we;  // load a whole entry and mark it active
    logic                  count_we;  // update the remaining count only
    logic                  off_we;    // free one voice
    logic                  off_all;   // free every voice
    logic [VOICE_BITS-1:0] addr;
    vmix_entry_t           entry;
  } vmix_tbl_cmd_t;

  function automatic logic [VOICE_BITS-1:0] to_idx(logic [3:0] v);
    logic [VOICE_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < VOICE_BITS; i++) begin
      if (i < 4) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] to_len(logic [23:0] v);
    logic [LENGTH_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < LENGTH_BITS; i++) begin
      if (i < 24) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [18:0] x);
    if (x > SAT_MAX) begin
      return 16'sh7FFF;
    end else if (x < SAT_MIN) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/vmix_voice_tbl.sv @@
// ----------------------------------------------------------------------------
// vmix_voice_tbl - voice table
// Active flags with reset, per-voice gain, pan and remaining count storage.
// ----------------------------------------------------------------------------
`default_nettype none

module vmix_voice_tbl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vmix_pkg::vmix_tbl_cmd_t             cmd_i,
  input  logic [vmix_pkg::VOICE_BITS-1:0]     rd_addr_i,
  output vmix_pkg::vmix_entry_t               rd_o,
  output logic [vmix_pkg::VOICES-1:0]         on_o
);
  import vmix_pkg::*;

  logic [VOICES-1:0] on_q;
  vmix_entry_t       entry_q [VOICES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q <= '0;
    end else begin
      priority if (cmd_i.off_all) begin
        on_q <= '0;
      end else if (cmd_i.entry_we) begin
        on_q[cmd_i.addr] <= 1'b1;
      end else if (cmd_i.off_we) begin
        on_q[cmd_i.addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.entry_we) begin
      entry_q[cmd_i.addr] <= cmd_i.entry;
    end else if (cmd_i.count_we) begin
      entry_q[cmd_i.addr].count <= cmd_i.entry.count;
    end
  end

  assign rd_o = entry_q[rd_addr_i];
  assign on_o = on_q;

endmodule

`default_nettype wire

@@ rtl/core/vmix_mul.sv @@
// ----------------------------------------------------------------------------
// vmix_mul - shared multiplier
// Signed 17x9 multiply with a registered product, reused for gain, pan and mix.
// ----------------------------------------------------------------------------
`default_nettype none

module vmix_mul (
  input  logic               clk_i,
  input  logic signed [16:0] a_i,
  input  logic signed [8:0]  b_i,
  output logic signed [25:0] p_o
);

  logic signed [25:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ rtl/core/voice_mixer_with_pan_and_stealing_core.sv @@
// ----------------------------------------------------------------------------
// voice_mixer_with_pan_and_stealing_core - stereo voice mixer
// Voice allocation with stealing, per-voice gain and pan, saturating mix.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_stall_o is high while an item is worked.
// A sample for an active voice makes five passes through the one shared
// multiplier (voice gain, left pan, right pan, left mix, right mix) before its
// count is written back. A play request with a free voice goes from ST_PICK to
// ST_EMIT; when all voices are busy the steal search walks the table one voice
// per cycle and ST_STEAL loads the voice with the lowest count. Stop items end
// in ST_IDLE; frame end waits in ST_EMIT. Results sit in an output register,
// so a new item can be accepted while the last result is still stalled; an
// item that produces a result waits for that register to drain.
`default_nettype none

module voice_mixer_with_pan_and_stealing_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vmix_pkg::vmix_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vmix_pkg::vmix_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i
);
  import vmix_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_PICK  = 11'b00000000010,
    ST_SCAN  = 11'b00000000100,
    ST_STEAL = 11'b00000001000,
    ST_CHECK = 11'b00000010000,
    ST_VOL   = 11'b00000100000,
    ST_PANL  = 11'b00001000000,
    ST_PANR  = 11'b00010000000,
    ST_MIXL  = 11'b00100000000,
    ST_MIXR  = 11'b01000000000,
    ST_EMIT  = 11'b10000000000
  } state_e;

  state_e                 state_q, state_d;
  vmix_in_t               item_q, item_d;
  logic [VOICE_BITS-1:0]  scan_q, scan_d;
  logic [VOICE_BITS-1:0]  pick_q, pick_d;
  logic [LENGTH_BITS:0]   best_q, best_d;
  logic [7:0]             vol_q, vol_d;
  logic [7:0]             pl_q, pl_d;
  logic [7:0]             pr_q, pr_d;
  logic signed [15:0]     left_q, left_d;
  logic signed [15:0]     right_q, right_d;
  logic [7:0]             master_q;
  vmix_out_t              out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  vmix_tbl_cmd_t          cmd;
  logic [VOICE_BITS-1:0]  rd_addr;
  vmix_entry_t            rd;
  logic [VOICES-1:0]      on_w;

  logic signed [16:0]     mul_a;
  logic signed [8:0]      mul_b;
  logic signed [25:0]     mul_p;

  logic                   accept;
  logic                   out_load;
  logic [VOICE_BITS-1:0]  in_idx;
  logic                   in_ok;
  logic [VOICE_BITS-1:0]  idx;
  logic [VOICE_BITS-1:0]  first_free;
  logic                   any_free;
  logic                   centre;
  logic [7:0]             ctr_side;
  logic signed [18:0]     mix_sum;
  logic [LENGTH_BITS-1:0] cnt_dec;
  logic [15:0]            mask;
  logic [3:0]             granted;

  vmix_voice_tbl u_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .rd_o      (rd),
    .on_o      (on_w)
  );

  vmix_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign in_idx     = to_idx(in_data_i.voice);
  assign in_ok      = (int'(in_data_i.voice) < VOICES);
  assign idx        = to_idx(item_q.voice);
  assign any_free   = ~&on_w;
  assign rd_addr    = (state_q == ST_SCAN) ? scan_q : idx;
  assign centre     = (rd.balance >= CENTRE_LO) && (rd.balance <= CENTRE_HI);
  assign ctr_side   = 8'(({2'b00, vol_q} + {1'b0, vol_q, 1'b0}) >> 2);
  assign cnt_dec    = rd.count - LENGTH_BITS'(1);

  // Lowest free voice wins
  always_comb begin
    first_free = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!on_w[i]) begin
        first_free = VOICE_BITS'(i);
      end
    end
  end

  always_comb begin
    mask    = '0;
    granted = '0;
    for (int i = 0; i < 16; i++) begin
      if (i < VOICES) begin
        mask[i] = on_w[i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (i < VOICE_BITS) begin
        granted[i] = pick_q[i];
      end
    end
  end

  // Floor of product / 256 added into the running sum
  always_comb begin
    if (state_q == ST_MIXR) begin
      mix_sum = {{3{right_q[15]}}, right_q} + {mul_p[25], mul_p[25:8]};
    end else begin
      mix_sum = {{3{left_q[15]}}, left_q} + {mul_p[25], mul_p[25:8]};
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    scan_d      = scan_q;
    pick_d      = pick_q;
    best_d      = best_q;
    vol_d       = vol_q;
    pl_d        = pl_q;
    pr_d        = pr_q;
    left_d      = left_q;
    right_d     = right_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mul_a       = '0;
    mul_b       = '0;

    cmd               = '0;
    cmd.addr          = idx;
    cmd.entry.gain    = item_q.gain;
    cmd.entry.balance = item_q.balance;
    cmd.entry.count   = to_len(item_q.sound_length);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          unique case (in_data_i.kind)
            KIND_PLAY:   state_d = ST_PICK;
            KIND_SAMPLE: begin
              if (in_ok && on_w[in_idx]) begin
                state_d = ST_CHECK;
              end
            end
            KIND_STOP: begin
              cmd.addr   = in_idx;
              cmd.off_we = in_ok;
            end
            KIND_STOP_ALL: cmd.off_all = 1'b1;
            KIND_FRAME:    state_d = ST_EMIT;
            default: ;
          endcase
        end
      end
      ST_PICK: begin
        if (any_free) begin
          cmd.addr     = first_free;
          cmd.entry_we = 1'b1;
          pick_d       = first_free;
          state_d      = ST_EMIT;
        end else begin
          scan_d  = '0;
          best_d  = '1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ({1'b0, rd.count} < best_q) begin
          best_d = {1'b0, rd.count};
          pick_d = scan_q;
        end
        if (scan_q == VOICE_BITS'(VOICES - 1)) begin
          state_d = ST_STEAL;
        end else begin
          scan_d = scan_q + VOICE_BITS'(1);
        end
      end
      ST_STEAL: begin
        cmd.addr     = pick_q;
        cmd.entry_we = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_CHECK: begin
        // Zero count: drop the sample and free the voice
        if (rd.count == '0) begin
          cmd.off_we = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          mul_a   = {9'b0, rd.gain};
          mul_b   = {1'b0, master_q};
          state_d = ST_VOL;
        end
      end
      ST_VOL: begin
        vol_d   = mul_p[15:8];
        mul_a   = {9'b0, PAN_FULL - rd.balance};
        mul_b   = {1'b0, mul_p[15:8]};
        state_d = ST_PANL;
      end
      ST_PANL: begin
        pl_d    = centre ? ctr_side : mul_p[15:8];
        mul_a   = {9'b0, rd.balance};
        mul_b   = {1'b0, vol_q};
        state_d = ST_PANR;
      end
      ST_PANR: begin
        pr_d    = centre ? ctr_side : mul_p[15:8];
        mul_a   = {item_q.sample[15], item_q.sample};
        mul_b   = {1'b0, pl_q};
        state_d = ST_MIXL;
      end
      ST_MIXL: begin
        left_d  = sat16(mix_sum);
        mul_a   = {item_q.sample[15], item_q.sample};
        mul_b   = {1'b0, pr_q};
        state_d = ST_MIXR;
      end
      ST_MIXR: begin
        right_d         = sat16(mix_sum);
        cmd.count_we    = 1'b1;
        cmd.entry.count = cnt_dec;
        cmd.off_we      = (cnt_dec == '0);
        state_d         = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (item_q.kind == KIND_FRAME) begin
            out_d.reply_kind    = REPLY_FRAME;
            out_d.granted_voice = '0;
            out_d.left_out      = left_q;
            out_d.right_out     = right_q;
            out_d.active_mask   = mask;
            left_d              = '0;
            right_d             = '0;
          end else begin
            out_d.reply_kind    = REPLY_GRANT;
            out_d.granted_voice = granted;
            out_d.left_out      = '0;
            out_d.right_out     = '0;
            out_d.active_mask   = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      master_q    <= MASTER_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      right_q     <= right_d;
      if (cfg_we_i) begin
        master_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    scan_q <= scan_d;
    pick_q <= pick_d;
    best_q <= best_d;
    vol_q  <= vol_d;
    pl_q   <= pl_d;
    pr_q   <= pr_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_scan_all_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (&on_w))
    else $error("steal search with a free voice");

  a_mix_voice_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIXL) |-> on_w[idx])
    else $error("mixing a sample of an inactive voice");

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && item_q.kind == KIND_FRAME) |=> (left_q == '0 && right_q == '0))
    else $error("accumulators not cleared after frame beat");
`endif

endmodule

`default_nettype wire

@@ sim/voice_mixer_with_pan_and_stealing_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_mixer_with_pan_and_stealing_core_tb - self-checking mixer bench
// Drives play, sample, stop and frame-end beats into the mixer, first from a
// short directed table and then as random frame-shaped traffic. A local model
// of the voice table, pan split and saturating sums predicts each reply not
// fixed by a directed row. Replies are compared field by field in arrival
// order. Master gain is changed between phases; both handshakes idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_mixer_with_pan_and_stealing_core_tb;

  import vmix_pkg::*;

  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
  localparam int         SETTLE_CYCLES    = VOICES + 8;
  localparam int         WATCHDOG_LIMIT   = 4000;

  typedef struct {
    vmix_in_t  item;
    bit        typed;
    vmix_out_t result;
  } stim_row_t;

  logic      clk_i    = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  vmix_in_t  in_data  = '0;
  logic      out_stall = 1'b0;
  logic      cfg_we   = 1'b0;
  logic [7:0] cfg_data = '0;

  logic      in_stall_o;
  logic      out_valid_o;
  vmix_out_t out_data_o;

  voice_mixer_with_pan_and_stealing_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Local copy of the voice table and mix sums
  logic                   v_on    [VOICES];
  logic [7:0]             v_gain  [VOICES];
  logic [7:0]             v_bal   [VOICES];
  logic [LENGTH_BITS-1:0] v_count [VOICES];
  int                     mix_left;
  int                     mix_right;
  logic [7:0]             master;

  vmix_out_t  expected_q[$];
  stim_row_t  dir_rows[$];
  int         err_count;
  int         item_count;
  int         reply_count;
  int         play_count;
  int         steal_count;
  int         clip_count;
  int         quiet_cycles = 0;
  bit         in_idle_en;
  bit         out_idle_en;

  function automatic int clip_pcm(int x);
    if (x > 32767) begin
      clip_count++;
      return 32767;
    end else if (x < -32768) begin
      clip_count++;
      return -32768;
    end
    return x;
  endfunction

  function automatic void mixer_reset();
    for (int v = 0; v < VOICES; v++) begin
      v_on[v]    = 1'b0;
      v_gain[v]  = '0;
      v_bal[v]   = '0;
      v_count[v] = '0;
    end
    mix_left  = 0;
    mix_right = 0;
    master    = MASTER_RESET;
  endfunction

  function automatic void mixer_step(input vmix_in_t it, output bit has,
                                     output vmix_out_t res);
    int                   pick;
    int                   vn;
    int                   vol;
    int                   pl;
    int                   pr;
    int                   s;
    logic [LENGTH_BITS:0] best;
    logic [15:0]          mask;
    has = 1'b0;
    res = '0;
    vn  = int'(it.voice);
    s   = int'($signed(it.sample));
    case (it.kind)
      KIND_PLAY: begin
        play_count++;
        pick = -1;
        for (int v = 0; v < VOICES; v++) begin
          if (!v_on[v] && pick < 0) pick = v;
        end
        // all busy: steal the voice closest to finishing
        if (pick < 0) begin
          steal_count++;
          pick = 0;
          best = '1;
          for (int v = 0; v < VOICES; v++) begin
            if ({1'b0, v_count[v]} < best) begin
              best = {1'b0, v_count[v]};
              pick = v;
            end
          end
        end
        v_on[pick]    = 1'b1;
        v_gain[pick]  = it.gain;
        v_bal[pick]   = it.balance;
        v_count[pick] = it.sound_length[LENGTH_BITS-1:0];
        has               = 1'b1;
        res.reply_kind    = REPLY_GRANT;
        res.granted_voice = pick[3:0];
      end
      KIND_SAMPLE: begin
        if (vn < VOICES && v_on[vn]) begin
          if (v_count[vn] == '0) begin
            v_on[vn] = 1'b0;
          end else begin
            vol = (int'(v_gain[vn]) * int'(master)) >> 8;
            pl  = ((255 - int'(v_bal[vn])) * vol) >> 8;
            pr  = (int'(v_bal[vn]) * vol) >> 8;
            if (v_bal[vn] >= CENTRE_LO && v_bal[vn] <= CENTRE_HI) begin
              pl = vol * 3 / 4;
              pr = pl;
            end
            mix_left  = clip_pcm(mix_left + ((s * pl) >>> 8));
            mix_right = clip_pcm(mix_right + ((s * pr) >>> 8));
            v_count[vn] = v_count[vn] - 1'b1;
            if (v_count[vn] == '0) v_on[vn] = 1'b0;
          end
        end
      end
      KIND_STOP: begin
        if (vn < VOICES) v_on[vn] = 1'b0;
      end
      KIND_STOP_ALL: begin
        for (int v = 0; v < VOICES; v++) v_on[v] = 1'b0;
      end
      KIND_FRAME: begin
        mask = '0;
        for (int v = 0; v < VOICES && v < 16; v++) begin
          if (v_on[v]) mask[v] = 1'b1;
        end
        has             = 1'b1;
        res.reply_kind  = REPLY_FRAME;
        res.left_out    = mix_left[15:0];
        res.right_out   = mix_right[15:0];
        res.active_mask = mask;
        mix_left  = 0;
        mix_right = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic vmix_in_t mk_item(logic [2:0] k, logic [3:0] v,
                                       logic [15:0] s, logic [23:0] len,
                                       logic [7:0] g, logic [7:0] b);
    vmix_in_t it;
    it.kind         = k;
    it.voice        = v;
    it.sample       = s;
    it.sound_length = len;
    it.gain         = g;
    it.balance      = b;
    return it;
  endfunction

  function automatic vmix_out_t mk_reply(logic k, logic [3:0] v, logic [15:0] l,
                                         logic [15:0] r, logic [15:0] m);
    vmix_out_t o;
    o.reply_kind    = k;
    o.granted_voice = v;
    o.left_out      = l;
    o.right_out     = r;
    o.active_mask   = m;
    return o;
  endfunction

  function automatic void add_row(vmix_in_t it, bit typed, vmix_out_t res);
    stim_row_t row;
    row.item   = it;
    row.typed  = typed;
    row.result = res;
    dir_rows.push_back(row);
  endfunction

  // Present one beat, hold it until accepted, then record what it should cause
  task automatic send_beat(input vmix_in_t it, input bit typed, input vmix_out_t typed_res);
    bit        has;
    vmix_out_t res;
    if (in_idle_en && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 32);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    mixer_step(it, has, res);
    if (has) expected_q.push_back(typed ? typed_res : res);
    item_count++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic set_master(input logic [7:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    master = value;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] pick_length(int long_pct);
    int r;
    r = $urandom_range(99);
    if (r < 4) return 24'd0;
    if (r < 9) return 24'($urandom);
    if (r < 9 + long_pct) return 24'($urandom_range(2000, 200));
    return 24'($urandom_range(12, 1));
  endfunction

  function automatic int pick_active_voice();
    int live[$];
    for (int v = 0; v < VOICES; v++) begin
      if (v_on[v]) live.push_back(v);
    end
    if (live.size() == 0) return -1;
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Frame-shaped random traffic: plays, samples of live voices, stops, frame ends
  task automatic run_random(input int n_items, input int play_pct, input int long_pct,
                            input bit pause_midway);
    int        sent;
    int        r;
    int        v;
    vmix_in_t  it;
    sent = 0;
    while (sent < n_items) begin
      it = mk_item(KIND_SAMPLE, 4'($urandom), pick_sample(), 24'($urandom),
                   8'($urandom), 8'($urandom));
      r  = $urandom_range(99);
      if (r < play_pct) begin
        it.kind         = KIND_PLAY;
        it.sound_length = pick_length(long_pct);
      end else if (r < 85) begin
        v = pick_active_voice();
        if (v >= 0 && $urandom_range(99) < 88) it.voice = v[3:0];
      end else if (r < 89) begin
        it.kind = KIND_STOP;
      end else if (r < 90) begin
        it.kind = KIND_STOP_ALL;
      end else if (r < 98) begin
        it.kind = KIND_FRAME;
      end else begin
        it.kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
      end
      send_beat(it, 1'b0, '0);
      if (it.kind <= KIND_FRAME) sent++;
      if (pause_midway && sent == n_items / 2) hold_until_drained();
    end
  endtask

  task automatic load_directed();
    vmix_out_t no_res;
    no_res = '0;
    add_row(mk_item(KIND_FRAME, 4'd0, 16'd0, 24'd0, 8'd0, 8'd0), 1'b1,
            mk_reply(REPLY_FRAME, 4'd0, 16'd0, 16'd0, 16'd0));
    add_row(mk_item(KIND_PLAY, 4'd9, 16'd0, 24'd3, 8'd255, 8'd0), 1'b1,
            mk_reply(REPLY_GRANT, 4'd0, 16'd0, 16'd0, 16'd0));
    add_row(mk_item(KIND_PLAY, 4'd0, 16'd0, 24'd1, 8'd255, PAN_FULL), 1'b1,
            mk_reply(REPLY_GRANT, 4'd1, 16'd0, 16'd0, 16'd0));
    // zero length: granted and active, but its first sample only frees it
    add_row(mk_item(KIND_PLAY, 4'd15, 16'hFFFF, 24'd0, 8'd255, 8'd128), 1'b1,
            mk_reply(REPLY_GRANT, 4'd2, 16'd0, 16'd0, 16'd0));
    add_row(mk_item(KIND_PLAY, 4'd0, 16'd0, 24'hFFFFFF, 8'd0, CENTRE_LO), 1'b1,
            mk_reply(REPLY_GRANT, 4'd3, 16'd0, 16'd0, 16'd0));
    add_row(mk_item(KIND_PLAY, 4'd0, 16'd0, 24'd2, 8'd128, CENTRE_HI), 1'b1,
            mk_reply(REPLY_GRANT, 4'd4, 16'd0, 16'd0, 16'd0));
    add_row(mk_item(KIND_SAMPLE, 4'd0, 16'h7FFF, 24'hFFFFFF, 8'hFF, 8'hFF), 1'b0, no_res);
    add_row(mk_item(KIND_SAMPLE, 4'd0, 16'h8000, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_SAMPLE, 4'd1, 16'h8000, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_SAMPLE, 4'd2, 16'd1234, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_SAMPLE, 4'd3, 16'hFFFF, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_SAMPLE, 4'd4, 16'h7FFF, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_SAMPLE, 4'd4, 16'h7FFF, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_SAMPLE, 4'd7, 16'h4000, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_SPARE_FIRST, 4'd0, 16'h7FFF, 24'd5, 8'd255, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_SPARE_LAST, 4'd15, 16'hFFFF, 24'hFFFFFF, 8'hFF, 8'hFF),
            1'b0, no_res);
    add_row(mk_item(KIND_FRAME, 4'd0, 16'd0, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_STOP, 4'd3, 16'd0, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_SAMPLE, 4'd3, 16'h7FFF, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_PLAY, 4'd0, 16'd0, 24'd5, 8'd200, 8'd97), 1'b0, no_res);
    add_row(mk_item(KIND_STOP_ALL, 4'd0, 16'd0, 24'd0, 8'd0, 8'd0), 1'b0, no_res);
    add_row(mk_item(KIND_FRAME, 4'd0, 16'd0, 24'd0, 8'd0, 8'd0), 1'b1,
            mk_reply(REPLY_FRAME, 4'd0, 16'd0, 16'd0, 16'd0));
  endtask

  always @(posedge clk_i) begin
    out_stall <= out_idle_en && ($urandom_range(99) < 32);
  end

  function automatic void report_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%04h, got 0x%04h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Reply checker
  always @(posedge clk_i) begin
    vmix_out_t exp_r;
    if (rst_n && out_valid_o === 1'b1 && out_stall === 1'b0) begin
      reply_count++;
      if (expected_q.size() == 0) begin
        $error("unexpected reply beat: 0x%h", out_data_o);
        err_count++;
      end else begin
        exp_r = expected_q.pop_front();
        report_field("reply_kind", 16'(exp_r.reply_kind), 16'(out_data_o.reply_kind));
        report_field("granted_voice", 16'(exp_r.granted_voice),
                     16'(out_data_o.granted_voice));
        report_field("left_out", exp_r.left_out, out_data_o.left_out);
        report_field("right_out", exp_r.right_out, out_data_o.right_out);
        report_field("active_mask", exp_r.active_mask, out_data_o.active_mask);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("** voice_mixer_with_pan_and_stealing_core: FAILED **");
      $finish;
    end
  end

  initial begin
    err_count    = 0;
    item_count   = 0;
    reply_count  = 0;
    play_count   = 0;
    steal_count  = 0;
    clip_count   = 0;
    in_idle_en   = 1'b1;
    out_idle_en  = 1'b1;
    mixer_reset();
    load_directed();
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
    end

    set_master(8'd255);
    run_random(200, 25, 20, 1'b0);

    // long stretch with both sides always ready
    set_master(8'd0);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    run_random(120, 25, 20, 1'b0);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;

    // dense plays of long sounds to force stealing
    set_master(8'($urandom));
    run_random(200, 45, 60, 1'b1);

    set_master(8'($urandom));
    run_random(180, 30, 35, 1'b0);

    set_master(8'd255);
    run_random(150, 20, 10, 1'b0);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d replies never arrived", expected_q.size());
      err_count++;
    end

    $display("Run covered %0d beats in, %0d replies out, %0d plays with %0d steals,",
             item_count, reply_count, play_count, steal_count);
    $display("%0d saturating adds, master gain at reset, 0, 255 and random values.",
             clip_count);
    if (err_count == 0) begin
      $display("** voice_mixer_with_pan_and_stealing_core: PASSED **");
    end else begin
      $display("** voice_mixer_with_pan_and_stealing_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
